>>> rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types, codes and phase tables shared by the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int STEP_COUNT_BITS = 16;
  localparam int BOUNCE_BITS     = 16;
  localparam int PHASE_BITS      = 4;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_IDX_BITS    = 1;

  localparam logic [PHASE_BITS-1:0]  HALF_PHASES  = 4'd8;
  localparam logic [PHASE_BITS-1:0]  FULL_PHASES  = 4'd4;
  localparam logic [BOUNCE_BITS-1:0] BOUNCE_RESET = 16'd300;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_LIMIT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    POS_CENTER = 2'd0,
    POS_LEFT   = 2'd1,
    POS_RIGHT  = 2'd2
  } pos_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HALF_STEP_MODE = 1'd0,
    REG_BOUNCE_STEPS   = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic                       direction;
    logic [STEP_COUNT_BITS-1:0] step_count;
    logic                       limit_side;
  } in_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       awake;
    logic       busy_res;
    logic       response_valid;
    logic [1:0] position;
  } out_t;

  function automatic logic [3:0] half_coils(input logic [PHASE_BITS-1:0] ph);
    logic [3:0] c;
    unique case (ph)
      4'd1:    c = 4'h5;
      4'd2:    c = 4'h4;
      4'd3:    c = 4'h6;
      4'd4:    c = 4'h2;
      4'd5:    c = 4'hA;
      4'd6:    c = 4'h8;
      4'd7:    c = 4'h9;
      4'd8:    c = 4'h1;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] full_coils(input logic [PHASE_BITS-1:0] ph);
    logic [3:0] c;
    unique case (ph)
      4'd1:    c = 4'h5;
      4'd2:    c = 4'h6;
      4'd3:    c = 4'hA;
      4'd4:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/sps_phase.sv
// ----------------------------------------------------------------------------
// sps_phase
// Phase advance and coil pattern lookup for one step, half or full step.
// ----------------------------------------------------------------------------
module sps_phase (
  input  logic [sps_pkg::PHASE_BITS-1:0] phase,
  input  logic                           forward,
  input  logic                           half_mode,
  output logic [sps_pkg::PHASE_BITS-1:0] phase_next,
  output logic [3:0]                     coils
);

  logic [sps_pkg::PHASE_BITS-1:0] top;

  always_comb begin
    top = half_mode ? sps_pkg::HALF_PHASES : sps_pkg::FULL_PHASES;
    if (forward) begin
      phase_next = (phase < top) ? phase + 4'd1 : 4'd1;
    end else begin
      phase_next = (phase > 4'd1 && phase <= top) ? phase - 4'd1 : top;
    end
    coils = half_mode ? sps_pkg::half_coils(phase_next) : sps_pkg::full_coils(phase_next);
  end

endmodule

>>> rtl/stepper_phase_sequencer_unit.sv
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_unit
// Stepper coil sequencer: start, step tick and limit requests in, one
// coil/status result out for every request.
// ----------------------------------------------------------------------------
// Every request is decoded against the sequencer state in a single
// combinational pass; the state and result register load at the accepting
// edge, so the result shows in the next cycle. A new request is taken
// in every cycle in which the result register is empty or its result is
// being taken; only a stalled output holds off the input. Configuration
// writes land at once and apply to the next request.
module stepper_phase_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sps_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sps_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [sps_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [sps_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  logic                                half_step_mode;
  logic [sps_pkg::BOUNCE_BITS-1:0]     bounce_steps;

  logic [sps_pkg::PHASE_BITS-1:0]      phase_index, phase_index_next;
  logic [sps_pkg::STEP_COUNT_BITS-1:0] steps_left, steps_left_next;
  logic                                move_direction, move_direction_next;
  logic [sps_pkg::BOUNCE_BITS:0]       bounce_left, bounce_left_next;
  logic [1:0]                          position_code, position_code_next;
  logic [3:0]                          coil_state, coil_state_next;
  logic                                awake_flag, awake_flag_next;
  logic                                resp;

  logic [sps_pkg::PHASE_BITS-1:0]      adv_phase;
  logic [3:0]                          adv_coils;
  logic                                accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  sps_phase u_phase (
    .phase      (phase_index),
    .forward    (move_direction),
    .half_mode  (half_step_mode),
    .phase_next (adv_phase),
    .coils      (adv_coils)
  );

  always_comb begin
    phase_index_next    = phase_index;
    steps_left_next     = steps_left;
    move_direction_next = move_direction;
    bounce_left_next    = bounce_left;
    position_code_next  = position_code;
    coil_state_next     = coil_state;
    awake_flag_next     = awake_flag;
    resp                = 1'b0;
    unique case (in_data.kind)
      sps_pkg::KIND_START: begin
        move_direction_next = in_data.direction;
        steps_left_next     = in_data.step_count;
        if (in_data.step_count == '0) begin
          if (position_code != sps_pkg::POS_CENTER && bounce_left[sps_pkg::BOUNCE_BITS]) begin
            position_code_next = sps_pkg::POS_CENTER;
          end
          coil_state_next = 4'h0;
          awake_flag_next = 1'b0;
          resp            = 1'b1;
        end
      end
      sps_pkg::KIND_TICK: begin
        if (steps_left != '0) begin
          if (!bounce_left[sps_pkg::BOUNCE_BITS]) begin
            bounce_left_next = bounce_left - 1'b1;
          end
          phase_index_next = adv_phase;
          coil_state_next  = adv_coils;
          awake_flag_next  = 1'b1;
          steps_left_next  = steps_left - 1'b1;
          if (steps_left == {{(sps_pkg::STEP_COUNT_BITS-1){1'b0}}, 1'b1}) begin
            if (position_code != sps_pkg::POS_CENTER && bounce_left_next[sps_pkg::BOUNCE_BITS]) begin
              position_code_next = sps_pkg::POS_CENTER;
            end
            coil_state_next = 4'h0;
            awake_flag_next = 1'b0;
            resp            = 1'b1;
          end
        end
      end
      sps_pkg::KIND_LIMIT: begin
        bounce_left_next   = {1'b0, bounce_steps};
        position_code_next = in_data.limit_side ? sps_pkg::POS_RIGHT : sps_pkg::POS_LEFT;
        steps_left_next    = '0;
        coil_state_next    = 4'h0;
        awake_flag_next    = 1'b0;
        resp               = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode <= 1'b1;
      bounce_steps   <= sps_pkg::BOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sps_pkg::REG_HALF_STEP_MODE: half_step_mode <= cfg_wdata[0];
        sps_pkg::REG_BOUNCE_STEPS:   bounce_steps   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index    <= '0;
      steps_left     <= '0;
      move_direction <= 1'b0;
      bounce_left    <= {1'b0, sps_pkg::BOUNCE_RESET};
      position_code  <= sps_pkg::POS_CENTER;
      coil_state     <= 4'h0;
      awake_flag     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase_index    <= phase_index_next;
        steps_left     <= steps_left_next;
        move_direction <= move_direction_next;
        bounce_left    <= bounce_left_next;
        position_code  <= position_code_next;
        coil_state     <= coil_state_next;
        awake_flag     <= awake_flag_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.coils          <= coil_state_next;
      out_data.awake          <= awake_flag_next;
      out_data.busy_res       <= (steps_left_next != '0);
      out_data.response_valid <= resp;
      out_data.position       <= position_code_next;
    end
  end

endmodule

>>> rtl/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the stepper phase sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sps_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input sps_pkg::out_t out_data
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stop_is_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.response_valid |->
      !out_data.busy_res && !out_data.awake && out_data.coils == 4'h0)
    else $error("stop response with motor still driven");

  a_sleep_coils_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.awake |-> out_data.coils == 4'h0)
    else $error("coils driven while asleep");

endmodule

bind stepper_phase_sequencer_unit sps_checker u_sps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
